>>> rtl/sil_pkg.sv
// ----------------------------------------------------------------------------
// sil_pkg
// shared constants, codes and structs of the sorted insert list
// ----------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_ELEMENT  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_CLEARED  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_PUT,
        S_RESP,
        S_RD_ISSUE,
        S_RD_DATA
    } seq_state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic              load;
        logic [DATA_W-1:0] value_out;
        status_t           status;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/sil_ram.sv
// ----------------------------------------------------------------------------
// sil_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sil_ram #(
    parameter int DEPTH  = 32,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/sil_seq.sv
// ----------------------------------------------------------------------------
// sil_seq
// sequencer: insert by shifting entries up from the top, read out in order
// ----------------------------------------------------------------------------
`default_nettype none

module sil_seq
    import sil_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        mode,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic              out_free,
    input  wire logic [DATA_W-1:0] rdata,
    output mem_req_t               mem_req,
    output result_t                result
);

    seq_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic              accept;
    logic              idx_is_last;

    assign in_ready    = (state_reg == S_IDLE) && out_free;
    assign accept      = in_valid && in_ready;
    assign idx_is_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        val_next         = val_reg;
        mem_req          = '0;
        result           = '0;
        result.status    = ST_INSERTED;
        result.last      = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next = value;
                    unique case (mode_t'(mode))
                        MODE_INSERT:
                        begin
                            if (count_reg == CNT_W'(LIST_DEPTH))
                            begin
                                result.load   = 1'b1;
                                result.status = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = '0;
                                mem_req.wdata = value;
                                count_next    = CNT_W'(1);
                                result.load   = 1'b1;
                                result.status = ST_INSERTED;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = ADDR_W'(count_reg - CNT_W'(1));
                                idx_next      = ADDR_W'(count_reg - CNT_W'(1));
                                state_next    = S_INS;
                            end
                        end
                        MODE_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                result.load   = 1'b1;
                                result.status = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_RD_ISSUE;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            count_next    = '0;
                            result.load   = 1'b1;
                            result.status = ST_CLEARED;
                        end
                        default:
                        begin
                            // unused mode: no change, no result
                        end
                    endcase
                end
            end

            S_INS:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = idx_reg + ADDR_W'(1);
                if ($signed(rdata) >= $signed(val_reg))
                begin
                    // move the entry up one place and keep scanning down
                    mem_req.wdata = rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = idx_reg - ADDR_W'(1);
                        idx_next      = idx_reg - ADDR_W'(1);
                    end
                end
                else
                begin
                    mem_req.wdata = val_reg;
                    count_next    = count_reg + CNT_W'(1);
                    state_next    = S_RESP;
                end
            end

            S_PUT:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = '0;
                mem_req.wdata = val_reg;
                count_next    = count_reg + CNT_W'(1);
                state_next    = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    result.load   = 1'b1;
                    result.status = ST_INSERTED;
                    state_next    = S_IDLE;
                end
            end

            S_RD_ISSUE:
            begin
                if (out_free)
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg;
                    state_next    = S_RD_DATA;
                end
            end

            S_RD_DATA:
            begin
                result.load      = 1'b1;
                result.value_out = rdata;
                result.status    = ST_ELEMENT;
                result.last      = idx_is_last;
                if (idx_is_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_RD_ISSUE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/sorted_insert_list.sv
// ----------------------------------------------------------------------------
// sorted_insert_list
// bounded ascending list of signed 32-bit values held in one ram
// ----------------------------------------------------------------------------
// Items are accepted one at a time. An insert reads the ram from the top
// down one entry per cycle and writes each entry not below the new value
// one place up, so the single ram read port sets the pace. A read out does a
// ram read, then an output register load, per stored value, waiting while
// that register is held; clear, a full insert and a read of an empty list
// load their result in the cycle they are accepted. Every result passes
// through an output register, and the next item is accepted once the
// sequencer is idle and that register is free or being taken.
`default_nettype none

module sorted_insert_list
    import sil_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               mode,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      value_out,
    output logic [2:0]                    status,
    output logic                          last
);

    mem_req_t          mem_req;
    result_t           result;
    logic [DATA_W-1:0] rdata;
    logic              out_free;

    logic              out_valid_reg;
    logic [DATA_W-1:0] value_out_reg;
    status_t           status_reg;
    logic              last_reg;

    assign out_free = !out_valid_reg || out_ready;

    sil_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .value    (value),
        .out_free (out_free),
        .rdata    (rdata),
        .mem_req  (mem_req),
        .result   (result)
    );

    sil_ram #(
        .DEPTH (LIST_DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.load)
        begin
            value_out_reg <= result.value_out;
            status_reg    <= result.status;
            last_reg      <= result.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

>>> rtl/sil_checker.sv
// ----------------------------------------------------------------------------
// sil_checker
// port-level checks of the sorted insert list
// ----------------------------------------------------------------------------
`default_nettype none

module sil_checker
    import sil_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [DATA_W-1:0] value_out,
    input wire logic [2:0]        status,
    input wire logic              last
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(value_out) && $stable(status) && $stable(last))
        else $error("output item changed while stalled");

    // only element items carry a value
    a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_ELEMENT |-> value_out == '0)
        else $error("non-element item with nonzero value");

    // single-item answers are always last
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_INSERTED || status == ST_FULL ||
                      status == ST_EMPTY || status == ST_CLEARED) |-> last)
        else $error("status item without last");

    // a read out in progress blocks new items
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> !in_ready)
        else $error("input ready in the middle of a read out");

endmodule

bind sorted_insert_list sil_checker u_sil_checker (.*);

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sorted insert list
// ----------------------------------------------------------------------------
// A short table of directed items walks the list through empty reads, the
// signed extremes, equal values, a fill to capacity with every value going
// to the front, inserts into a full list, ignored items and clears. Random
// episodes follow: a clear now and then, a burst of inserts (sometimes past
// capacity) with reads, clears and stray items mixed in, and a closing read. Every
// accepted item goes through a shadow copy of the list to build the expected
// results, and each result is checked field by field in order. Four phases
// vary sender idling and receiver stalling.
// ----------------------------------------------------------------------------

module tb_top;

    import sil_pkg::*;

    localparam logic [1:0] MODE_NONE   = 2'd3;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         DRAIN_WAIT  = 80;
    localparam int         PHASE_ITEMS = 90;
    localparam int         N_ROWS      = 18;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        status_t                  st;
        logic                     lst;
    } list_result_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [DATA_W-1:0] val;
        logic [7:0]        reps;
        logic [DATA_W-1:0] step;
        logic              typed;
        status_t           exp_st;
    } stim_row_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic [1:0]               mode      = MODE_INSERT;
    logic signed [DATA_W-1:0] value     = '0;
    logic                     out_ready = 1'b0;
    logic                     in_ready;
    logic                     out_valid;
    logic signed [DATA_W-1:0] value_out;
    logic [2:0]               status;
    logic                     last;

    logic signed [DATA_W-1:0] shadow_list[$];
    list_result_t             pending_results[$];

    int send_idle    = 0;
    int recv_stall   = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int n_inserts    = 0;
    int n_dropped    = 0;
    int n_reads      = 0;
    int n_empty      = 0;
    int n_clears     = 0;
    int n_ignored    = 0;

    stim_row_t directed_rows[N_ROWS] = '{
        '{MODE_READ,   32'h0000_0000, 8'd1,  32'd0,        1'b1, ST_EMPTY},
        '{MODE_INSERT, 32'h0000_0000, 8'd1,  32'd0,        1'b1, ST_INSERTED},
        '{MODE_INSERT, 32'h8000_0000, 8'd1,  32'd0,        1'b1, ST_INSERTED},
        '{MODE_INSERT, 32'h7fff_ffff, 8'd1,  32'd0,        1'b1, ST_INSERTED},
        '{MODE_INSERT, 32'h0000_0000, 8'd1,  32'd0,        1'b0, ST_INSERTED},
        '{MODE_INSERT, 32'hffff_ffff, 8'd1,  32'd0,        1'b0, ST_INSERTED},
        '{MODE_INSERT, 32'h0000_0001, 8'd1,  32'd0,        1'b0, ST_INSERTED},
        '{MODE_NONE,   32'hffff_ffff, 8'd1,  32'd0,        1'b0, ST_INSERTED},
        '{MODE_READ,   32'hffff_ffff, 8'd1,  32'd0,        1'b0, ST_INSERTED},
        '{MODE_CLEAR,  32'h5555_5555, 8'd1,  32'd0,        1'b1, ST_CLEARED},
        '{MODE_READ,   32'haaaa_aaaa, 8'd1,  32'd0,        1'b1, ST_EMPTY},
        '{MODE_CLEAR,  32'h0000_0000, 8'd1,  32'd0,        1'b1, ST_CLEARED},
        '{MODE_INSERT, 32'h4000_0000, 8'd32, 32'hffff_fffd, 1'b0, ST_INSERTED},
        '{MODE_INSERT, 32'h0000_0005, 8'd1,  32'd0,        1'b1, ST_FULL},
        '{MODE_INSERT, 32'h8000_0000, 8'd1,  32'd0,        1'b1, ST_FULL},
        '{MODE_READ,   32'h0000_0000, 8'd1,  32'd0,        1'b0, ST_INSERTED},
        '{MODE_NONE,   32'h0000_0000, 8'd1,  32'd0,        1'b0, ST_INSERTED},
        '{MODE_CLEAR,  32'hffff_ffff, 8'd1,  32'd0,        1'b1, ST_CLEARED}
    };

    int send_pct[4] = '{0, 54, 0, 38};
    int recv_pct[4] = '{0, 0, 54, 38};

    sorted_insert_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .value_out (value_out),
        .status    (status),
        .last      (last)
    );

    always #4 clk = ~clk;

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // shadow list update and expected results for one accepted item
    function automatic void predict_list_results(input logic [1:0] op,
                                                 input logic signed [DATA_W-1:0] val,
                                                 input bit queue_it);
        list_result_t r;
        int           pos;
        r.val = '0;
        r.lst = 1'b1;
        r.st  = ST_INSERTED;
        case (op)
            MODE_INSERT:
            begin
                n_inserts++;
                if (shadow_list.size() >= LIST_DEPTH)
                begin
                    n_dropped++;
                    r.st = ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < shadow_list.size() && shadow_list[pos] < val)
                        pos++;
                    shadow_list.insert(pos, val);
                end
                if (queue_it)
                    pending_results.push_back(r);
            end
            MODE_READ:
            begin
                n_reads++;
                if (shadow_list.size() == 0)
                begin
                    n_empty++;
                    r.st = ST_EMPTY;
                    if (queue_it)
                        pending_results.push_back(r);
                end
                else
                begin
                    for (int i = 0; i < shadow_list.size(); i++)
                    begin
                        r.val = shadow_list[i];
                        r.st  = ST_ELEMENT;
                        r.lst = (i == shadow_list.size() - 1);
                        if (queue_it)
                            pending_results.push_back(r);
                    end
                end
            end
            MODE_CLEAR:
            begin
                n_clears++;
                shadow_list.delete();
                r.st = ST_CLEARED;
                if (queue_it)
                    pending_results.push_back(r);
            end
            default:
                n_ignored++;
        endcase
    endfunction

    // present one item, with random idle cycles first, and wait for it to be taken
    task automatic offer_item(input logic [1:0] op, input logic [DATA_W-1:0] val);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        value    <= val;
        do
            @(posedge clk);
        while (!in_ready);
        if (op != MODE_NONE)
            items_sent++;
    endtask

    task automatic send_and_predict(input logic [1:0] op, input logic [DATA_W-1:0] val);
        offer_item(op, val);
        predict_list_results(op, val, 1'b1);
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_insert_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 6))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = $urandom_range(0, 15) - 8;
            3: v = (shadow_list.size() != 0) ?
                   shadow_list[$urandom_range(0, shadow_list.size() - 1)] : $urandom();
            4: v = (shadow_list.size() != 0) ?
                   shadow_list[$urandom_range(0, shadow_list.size() - 1)] + 1 : $urandom();
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic random_episode();
        int burst;
        int pick;
        if ($urandom_range(0, 1) == 0)
            send_and_predict(MODE_CLEAR, $urandom());
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 36) : $urandom_range(1, 12);
        for (int i = 0; i < burst; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_and_predict(MODE_NONE, $urandom());
            else if (pick < 15)
                send_and_predict(MODE_READ, $urandom());
            else if (pick < 18)
                send_and_predict(MODE_CLEAR, $urandom());
            else
                send_and_predict(MODE_INSERT, pick_insert_value());
        end
        send_and_predict(MODE_READ, $urandom());
    endtask

    // result side: random stalls, in-order checking, quiet-cycle count
    always @(posedge clk)
    begin
        list_result_t exp_r;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected result value_out=%0d status=%0d last=%0b",
                                          value_out, status, last));
            else
            begin
                exp_r = pending_results.pop_front();
                if (value_out !== exp_r.val)
                    report_mismatch($sformatf("value_out got %0d expected %0d",
                                              value_out, exp_r.val));
                if (status !== exp_r.st)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              status, exp_r.st));
                if (last !== exp_r.lst)
                    report_mismatch($sformatf("last got %0b expected %0b",
                                              last, exp_r.lst));
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending_results.size());
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        stim_row_t         row;
        logic [DATA_W-1:0] v;
        list_result_t      typed_r;

        @(posedge rst_n);
        @(posedge clk);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle  = send_pct[ph];
            recv_stall = recv_pct[ph];
            if (ph == 0)
            begin
                for (int i = 0; i < N_ROWS; i++)
                begin
                    row = directed_rows[i];
                    v   = row.val;
                    for (int k = 0; k < row.reps; k++)
                    begin
                        offer_item(row.op, v);
                        if (row.typed)
                        begin
                            typed_r.val = '0;
                            typed_r.st  = row.exp_st;
                            typed_r.lst = 1'b1;
                            pending_results.push_back(typed_r);
                        end
                        predict_list_results(row.op, v, !row.typed);
                        v = v + row.step;
                    end
                end
            end
            while (items_sent < (ph + 1) * PHASE_ITEMS)
                random_episode();
            hold_until_drained();
        end

        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d items: %0d inserts (%0d dropped on a full list), %0d reads",
                 items_sent, n_inserts, n_dropped, n_reads);
        $display("%0d empty reads, %0d clears, %0d ignored items, %0d results checked",
                 n_empty, n_clears, n_ignored, results_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sil_pkg.sv
rtl/sil_ram.sv
rtl/sil_seq.sv
rtl/sorted_insert_list.sv
rtl/sil_checker.sv
sim/tb_top.sv
